// ----- src/tvrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tvrs_pkg;

  localparam logic [7:0] HOLD_BYTE = 8'hFE;
  localparam logic [7:0] REST_BYTE = 8'hFF;

  localparam logic [1:0] CMD_NONE     = 2'd0;
  localparam logic [1:0] CMD_NOTE_ON  = 2'd1;
  localparam logic [1:0] CMD_GATE_OFF = 2'd2;

  localparam logic [2:0] REG_ROW_FRAMES   = 3'd0;
  localparam logic [2:0] REG_ROW_COUNT    = 3'd1;
  localparam logic [2:0] REG_SOPRANO_WAVE = 3'd2;
  localparam logic [2:0] REG_ALTO_WAVE    = 3'd3;
  localparam logic [2:0] REG_BASS_WAVE    = 3'd4;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 11;
  localparam int ROW_W       = 10;

  typedef struct packed {
    logic        action;
    logic [9:0]  load_row;
    logic [7:0]  load_soprano;
    logic [7:0]  load_alto;
    logic [7:0]  load_bass;
  } in_t;

  typedef struct packed {
    logic [1:0]  soprano_cmd;
    logic [7:0]  soprano_note;
    logic [7:0]  soprano_wave;
    logic [1:0]  alto_cmd;
    logic [7:0]  alto_note;
    logic [7:0]  alto_wave;
    logic [1:0]  bass_cmd;
    logic [7:0]  bass_note;
    logic [7:0]  bass_wave;
    logic [9:0]  row_now;
  } out_t;

  typedef struct packed {
    logic [7:0]  frame_len;
    logic [10:0] loop_len;
    logic [7:0]  soprano_waveform;
    logic [7:0]  alto_waveform;
    logic [7:0]  bass_waveform;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        start;
    logic [9:0]  row_now;
  } pend_t;

endpackage

`default_nettype wire

// ----- src/three_voice_row_sequencer.sv -----
`timescale 1ns / 1ps
`default_nettype none

// A tick that starts or releases a row fills the pending slot, then the output register.
// One item, load or tick, is taken every cycle unless stalled; loads and other ticks give
// no result. Each item needs at most one row store access, so only a receiver that stalls
// while both the pending slot and the output register are full holds off the input.
// Reset clears the row pointer, the frame position and the pending results, and sets the
// registers to eight frames per row, one row and zero waveforms; the row store is not cleared.

module three_voice_row_sequencer
  import tvrs_pkg::*;
#(
  parameter int MAX_ROW_COUNT = 1024,
  parameter int GATE_GAP      = 2
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   item_valid,
  output logic                        item_stall,
  input  wire in_t                    item,
  output logic                        result_valid,
  input  wire logic                   result_stall,
  output out_t                        result,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_ROW_COUNT);

  cfg_t          cfg;
  pend_t         pend;
  logic          pend_take;
  logic          we;
  logic [AW-1:0] waddr;
  logic [23:0]   wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic [23:0]   rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_len        <= 8'd8;
      cfg.loop_len         <= 11'd1;
      cfg.soprano_waveform <= 8'd0;
      cfg.alto_waveform    <= 8'd0;
      cfg.bass_waveform    <= 8'd0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_FRAMES:   cfg.frame_len        <= cfg_data[7:0];
        REG_ROW_COUNT:    cfg.loop_len         <= cfg_data;
        REG_SOPRANO_WAVE: cfg.soprano_waveform <= cfg_data[7:0];
        REG_ALTO_WAVE:    cfg.alto_waveform    <= cfg_data[7:0];
        REG_BASS_WAVE:    cfg.bass_waveform    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  tvrs_frame_ctl #(
    .MAX_ROW_COUNT(MAX_ROW_COUNT),
    .GATE_GAP     (GATE_GAP),
    .AW           (AW)
  ) u_ctl (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .cfg       (cfg),
    .pend_take (pend_take),
    .pend      (pend),
    .we        (we),
    .waddr     (waddr),
    .wdata     (wdata),
    .re        (re),
    .raddr     (raddr)
  );

  tvrs_row_mem #(
    .DEPTH(MAX_ROW_COUNT),
    .AW   (AW)
  ) u_mem (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  tvrs_out_stage u_out (
    .clk         (clk),
    .rst         (rst),
    .pend        (pend),
    .rdata       (rdata),
    .cfg         (cfg),
    .pend_take   (pend_take),
    .result      (result),
    .result_valid(result_valid),
    .result_stall(result_stall)
  );

endmodule

`default_nettype wire

// ----- src/tvrs_row_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tvrs_row_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [23:0]   wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [23:0]   rdata
);

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/tvrs_frame_ctl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tvrs_frame_ctl
  import tvrs_pkg::*;
#(
  parameter int MAX_ROW_COUNT = 1024,
  parameter int GATE_GAP      = 2,
  parameter int AW            = 10
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire in_t           item,
  input  wire logic          item_valid,
  output logic               item_stall,
  input  wire cfg_t          cfg,
  input  wire logic          pend_take,
  output pend_t              pend,
  output logic               we,
  output logic      [AW-1:0] waddr,
  output logic      [23:0]   wdata,
  output logic               re,
  output logic      [AW-1:0] raddr
);

  localparam int CW   = $clog2(MAX_ROW_COUNT + 1);
  localparam int CNTW = (CW > 11) ? CW : 11;
  localparam logic [7:0] GAP = 8'(GATE_GAP);

  logic [AW-1:0]   ptr;
  logic [AW-1:0]   ptr_next;
  logic [7:0]      pos;
  logic [7:0]      pos_next;

  logic            accept;
  logic            tick;
  logic [7:0]      frames;
  logic [CNTW-1:0] count;
  logic [CNTW-1:0] rc_ext;
  logic [7:0]      release_raw;
  logic [7:0]      release_pos;
  logic [AW-1:0]   ptr0;
  logic [AW-1:0]   ptr1;
  logic [7:0]      pos1;
  logic [7:0]      pos2;
  logic            is_start;
  logic            is_rel;
  logic [31:0]     load_row_ext;
  logic [CNTW-1:0] ptr1_ext;

  function automatic logic [AW-1:0] step_row(input logic [AW-1:0] p,
                                             input logic [CNTW-1:0] c);
    logic [CNTW-1:0] s;
    s = CNTW'(p) + CNTW'(1);
    return (s >= c) ? '0 : s[AW-1:0];
  endfunction

  assign item_stall = pend.valid && !pend_take;
  assign accept     = item_valid && !item_stall;
  assign tick       = accept && item.action;

  assign frames = (cfg.frame_len < 8'd2) ? 8'd2 : cfg.frame_len;
  assign rc_ext = CNTW'(cfg.loop_len);

  always_comb begin
    if (rc_ext == '0) begin
      count = CNTW'(1);
    end else if (rc_ext > CNTW'(MAX_ROW_COUNT)) begin
      count = CNTW'(MAX_ROW_COUNT);
    end else begin
      count = rc_ext;
    end
  end

  always_comb begin
    release_raw = (frames > GAP) ? frames - GAP : 8'd1;
    release_pos = release_raw;
    if (release_pos == 8'd0) begin
      release_pos = 8'd1;
    end
    if (release_pos > frames - 8'd1) begin
      release_pos = frames - 8'd1;
    end
  end

  always_comb begin
    ptr0 = (CNTW'(ptr) >= count) ? '0 : ptr;
    if (pos >= frames) begin
      ptr1 = step_row(ptr0, count);
      pos1 = 8'd0;
    end else begin
      ptr1 = ptr0;
      pos1 = pos;
    end
    is_start = (pos1 == 8'd0);
    is_rel   = !is_start && (pos1 == release_pos);
    pos2     = pos1 + 8'd1;
    if (pos2 >= frames) begin
      pos_next = 8'd0;
      ptr_next = step_row(ptr1, count);
    end else begin
      pos_next = pos2;
      ptr_next = ptr1;
    end
  end

  assign ptr1_ext     = CNTW'(ptr1);
  assign load_row_ext = 32'(item.load_row);

  assign we    = accept && !item.action && (load_row_ext < 32'(MAX_ROW_COUNT));
  assign waddr = load_row_ext[AW-1:0];
  assign wdata = {item.load_bass, item.load_alto, item.load_soprano};
  assign re    = tick && (is_start || is_rel);
  assign raddr = is_start ? ptr1 : step_row(ptr1, count);

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
      pos <= 8'd0;
    end else if (tick) begin
      ptr <= ptr_next;
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
    end else if (re) begin
      pend.valid <= 1'b1;
    end else if (pend_take) begin
      pend.valid <= 1'b0;
    end
    if (re) begin
      pend.start   <= is_start;
      pend.row_now <= ptr1_ext[ROW_W-1:0];
    end
  end

  a_start_then_one: assert property (@(posedge clk) disable iff (rst)
    tick && is_start |=> pos == 8'd1)
    else $error("position after row start is not one");

  a_pend_holds: assert property (@(posedge clk) disable iff (rst)
    pend.valid && !pend_take |=> pend.valid && $stable(pend.row_now))
    else $error("pending result lost while held");

  a_read_needs_room: assert property (@(posedge clk) disable iff (rst)
    re |-> !pend.valid || pend_take)
    else $error("row read issued over a held pending result");

endmodule

`default_nettype wire

// ----- src/tvrs_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tvrs_out_stage
  import tvrs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire pend_t       pend,
  input  wire logic [23:0] rdata,
  input  wire cfg_t        cfg,
  output logic             pend_take,
  output out_t             result,
  output logic             result_valid,
  input  wire logic        result_stall
);

  out_t result_next;
  logic [7:0] sop_b;
  logic [7:0] alt_b;
  logic [7:0] bas_b;

  assign sop_b = rdata[7:0];
  assign alt_b = rdata[15:8];
  assign bas_b = rdata[23:16];

  assign pend_take = pend.valid && (!result_valid || !result_stall);

  function automatic logic [17:0] voice(input logic start, input logic [7:0] b,
                                        input logic [7:0] wave);
    logic [1:0] cmd;
    logic [7:0] note;
    logic [7:0] w;
    cmd  = CMD_NONE;
    note = 8'd0;
    w    = 8'd0;
    if (start) begin
      if (b == REST_BYTE) begin
        cmd = CMD_GATE_OFF;
      end else if (b != HOLD_BYTE) begin
        cmd  = CMD_NOTE_ON;
        note = b;
        w    = wave;
      end
    end else if (b != HOLD_BYTE) begin
      cmd = CMD_GATE_OFF;
    end
    return {cmd, note, w};
  endfunction

  always_comb begin
    {result_next.soprano_cmd, result_next.soprano_note, result_next.soprano_wave} =
      voice(pend.start, sop_b, cfg.soprano_waveform);
    {result_next.alto_cmd, result_next.alto_note, result_next.alto_wave} =
      voice(pend.start, alt_b, cfg.alto_waveform);
    {result_next.bass_cmd, result_next.bass_note, result_next.bass_wave} =
      voice(pend.start, bas_b, cfg.bass_waveform);
    result_next.row_now = pend.row_now;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (pend_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pend_take) begin
      result <= result_next;
    end
  end

  a_note_not_code: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.soprano_cmd == CMD_NOTE_ON |->
      result.soprano_note != HOLD_BYTE && result.soprano_note != REST_BYTE)
    else $error("note-on carries a hold or rest code");

  a_release_no_note: assert property (@(posedge clk) disable iff (rst)
    pend_take && !pend.start |=>
      result.soprano_cmd != CMD_NOTE_ON && result.alto_cmd != CMD_NOTE_ON &&
      result.bass_cmd != CMD_NOTE_ON)
    else $error("release result carries a note-on");

endmodule

`default_nettype wire
